// ===== sv/pic_pkg.sv =====
// Shared types and codes for the programmable interrupt controller.
// Holds the request and response payload structs and the action codes.
// No dependencies.
`default_nettype none

package pic_pkg;

   typedef enum logic [1:0] {
      ACT_RAISE = 2'd0,
      ACT_POLL  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_WRITE = 2'd3
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [2:0]  irq_line;
      logic        port_sel;
      logic [7:0]  write_data;
   } req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [7:0]  vector;
      logic        vector_valid;
   } rsp_type;

   localparam logic PORT_CMD  = 1'b0;
   localparam logic PORT_DATA = 1'b1;

   // End-of-interrupt codes carried in command bits 7..5.
   localparam logic [2:0] EOI_NONSPECIFIC = 3'd1;
   localparam logic [2:0] EOI_SPECIFIC    = 3'd3;

   localparam logic [7:0] MASK_RESET = 8'hFF;
   localparam logic [7:0] BASE_RESET = 8'h08;
   localparam logic [7:0] BASE_KEEP  = 8'hF8;

endpackage

`default_nettype wire

// ===== sv/programmable_interrupt_controller.sv =====
// Eight-line interrupt controller with fixed priority, line 0 highest.
// Depends on pic_pkg for the payload structs and the action codes.
`default_nettype none

// One item is accepted every cycle when the result side keeps up. Each item
// passes through an input register and then a result register, where its
// result is offered; the request/in-service/mask update and the priority
// encode happen combinationally between those registers.
// The result register lets a new item be taken while an older result waits.
module programmable_interrupt_controller
   import pic_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      INIT_READY = 3'b001,
      INIT_BASE  = 3'b010,
      INIT_MODE  = 3'b100
   } init_type;

   function automatic logic [2:0] low_index(input logic [7:0] v);
      logic [2:0] idx;
      idx = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            idx = 3'(i);
         end
      end
      return idx;
   endfunction

   // Input stage.
   logic     in_vld_ff;
   req_type  in_ff;
   // Result stage.
   logic     rsp_vld_ff;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;

   // Controller state.
   logic [7:0] request_ff,    request_in;
   logic [7:0] in_service_ff, in_service_in;
   logic [7:0] mask_ff,       mask_in;
   logic [7:0] base_ff,       base_in;
   init_type   init_ff,       init_in;
   logic       mode_exp_ff,   mode_exp_in;
   logic       isr_sel_ff,    isr_sel_in;

   logic       advance;
   logic [7:0] pending;
   logic [7:0] pend_low;
   logic [7:0] cmd;

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   assign pending  = request_ff & ~mask_ff;
   // Isolate the lowest set bit of the pending word.
   assign pend_low = pending & (~pending + 8'd1);
   assign cmd      = in_ff.write_data;

   always_comb begin
      request_in    = request_ff;
      in_service_in = in_service_ff;
      mask_in       = mask_ff;
      base_in       = base_ff;
      init_in       = init_ff;
      mode_exp_in   = mode_exp_ff;
      isr_sel_in    = isr_sel_ff;
      rsp_in        = '0;

      case (in_ff.action)
         ACT_RAISE: begin
            request_in = request_ff | (8'd1 << in_ff.irq_line);
         end
         ACT_POLL: begin
            if (pending != 8'd0) begin
               request_in          = request_ff & ~pend_low;
               in_service_in       = in_service_ff | pend_low;
               rsp_in.vector       = base_ff + {5'd0, low_index(pending)};
               rsp_in.vector_valid = 1'b1;
            end
         end
         ACT_READ: begin
            if (in_ff.port_sel == PORT_CMD) begin
               rsp_in.read_data = isr_sel_ff ? in_service_ff : request_ff;
            end else begin
               rsp_in.read_data = mask_ff;
            end
         end
         ACT_WRITE: begin
            if (in_ff.port_sel == PORT_CMD) begin
               if (cmd[4]) begin
                  // Start of initialization clears the interrupt registers.
                  mode_exp_in   = cmd[0];
                  mask_in       = 8'd0;
                  in_service_in = 8'd0;
                  request_in    = 8'd0;
                  isr_sel_in    = 1'b0;
                  init_in       = INIT_BASE;
               end else if (cmd[3]) begin
                  if (cmd[1]) begin
                     isr_sel_in = cmd[0];
                  end
               end else if (cmd[7:5] == EOI_NONSPECIFIC) begin
                  // Clearing the lowest set bit; a zero register stays zero.
                  in_service_in = in_service_ff & (in_service_ff - 8'd1);
               end else if (cmd[7:5] == EOI_SPECIFIC) begin
                  in_service_in = in_service_ff & ~(8'd1 << cmd[2:0]);
               end
            end else begin
               case (init_ff)
                  INIT_BASE: begin
                     base_in = cmd & BASE_KEEP;
                     init_in = mode_exp_ff ? INIT_MODE : INIT_READY;
                  end
                  INIT_MODE: begin
                     init_in = INIT_READY;
                  end
                  default: begin
                     mask_in = cmd;
                  end
               endcase
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         request_ff    <= 8'd0;
         in_service_ff <= 8'd0;
         mask_ff       <= MASK_RESET;
         base_ff       <= BASE_RESET;
         init_ff       <= INIT_READY;
         mode_exp_ff   <= 1'b0;
         isr_sel_ff    <= 1'b0;
      end else begin
         if (req_ready) begin
            in_vld_ff <= req_valid;
         end
         if (advance) begin
            rsp_vld_ff    <= 1'b1;
            request_ff    <= request_in;
            in_service_ff <= in_service_in;
            mask_ff       <= mask_in;
            base_ff       <= base_in;
            init_ff       <= init_in;
            mode_exp_ff   <= mode_exp_in;
            isr_sel_ff    <= isr_sel_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // An acknowledged line is in service and no longer requested right after.
   assert property (@(posedge clock) disable iff (reset)
      $past(!reset && advance && in_ff.action == ACT_POLL && pending != 8'd0)
      |-> in_service_ff[rsp_ff.vector[2:0]] && !request_ff[rsp_ff.vector[2:0]])
      else $error("acknowledged line not moved to in-service");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ff.vector_valid |-> rsp_ff.vector == 8'd0)
      else $error("vector set without a successful poll");

   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.vector_valid |-> rsp_ff.read_data == 8'd0)
      else $error("read data set on a poll result");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_vld_ff && rsp_vld_ff && !rsp_ready)
      else $error("input stalled while the pipeline could move");
`endif

endmodule

`default_nettype wire
